[design/ptc_pkg.sv]
package ptc_pkg;

    localparam int ROOT_DEPTH = 16384;
    localparam int ROOT_AW    = 14;

    // quarter wave of the truncated 127*sin table
    localparam logic [6:0] QSINE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
        7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,
        7'd59,  7'd62,  7'd65,  7'd67,  7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,
        7'd85,  7'd87,  7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
        7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116, 7'd117, 7'd118,
        7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126,
        7'd126, 7'd126, 7'd126, 7'd126, 7'd127
    };

    // attribute byte per colour scheme and colour slot
    localparam logic [7:0] SCHEME_ATTR [8][3] = '{
        '{8'h00, 8'h01, 8'h09},
        '{8'h00, 8'h02, 8'h0A},
        '{8'h00, 8'h03, 8'h0B},
        '{8'h00, 8'h04, 8'h0C},
        '{8'h00, 8'h05, 8'h0D},
        '{8'h00, 8'h06, 8'h0E},
        '{8'h00, 8'h07, 8'h0F},
        '{8'h00, 8'h08, 8'h06}
    };

    localparam logic [7:0] LEVEL_GLYPH [8] = '{
        8'h20, 8'h20, 8'h3A, 8'h3A, 8'h6F, 8'h4F, 8'h4F, 8'h51
    };
    localparam logic [1:0] LEVEL_SLOT [8] = '{
        2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2
    };

    localparam logic [7:0] LOW_ATTR_KEEP = 8'h08;
    localparam logic [7:0] LOW_ATTR_SET  = 8'h01;
    localparam logic [6:0] MOVE_OFF_A    = 7'd60;
    localparam logic [6:0] MOVE_OFF_B    = 7'd64;
    localparam logic [7:0] QUARTER_TURN  = 8'd64;
    localparam logic [9:0] RECIP_THIRD   = 10'd171;

    typedef struct packed {
        logic               we;
        logic [ROOT_AW-1:0] addr;
        logic [7:0]         data;
        logic               done;
    } t_fill;

    function automatic logic [7:0] sine_at(input logic [7:0] a);
        logic [6:0] i;
        logic [6:0] m;
        logic [7:0] s;
        i = a[6:0];
        if (i <= 7'd64) begin
            m = QSINE[i];
        end else begin
            m = QSINE[7'(8'd128 - {1'b0, i})];
        end
        s = {1'b0, m};
        return a[7] ? 8'(-s) : s;
    endfunction

    // half sine, truncated toward zero, plus offset, wrapped to 16 bits
    function automatic logic [15:0] move_coord(input logic [7:0] a, input logic [6:0] off);
        logic [7:0] s;
        logic [8:0] e;
        logic [8:0] h;
        s = sine_at(a);
        e = {s[7], s} + {8'b0, s[7]};
        h = {e[8], e[8:1]};
        return {{7{h[8]}}, h} + {9'b0, off};
    endfunction

endpackage

[design/ptc_ram.sv]
module ptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    parameter int NRD   = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr [NRD],
    output logic [WIDTH-1:0]         o_rdata [NRD]
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata [NRD];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            for (int k = 0; k < NRD; k++) begin
                r_rdata[k] <= mem[i_raddr[k]];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/ptc_root_fill.sv]
module ptc_root_fill
    import ptc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    output t_fill o_fill
);

    logic [ROOT_AW:0] r_idx;
    logic [7:0]       r_root;
    logic [7:0]       n_root;
    logic [15:0]      w_n;
    logic [8:0]       w_r1;
    logic [8:0]       w_r2;
    logic             w_c1;
    logic             w_c2;
    logic             w_done;

    assign w_done = r_idx[ROOT_AW];
    assign w_n    = {r_idx[ROOT_AW-1:0], 2'b00};
    assign w_r1   = {1'b0, r_root} + 9'd1;
    assign w_r2   = {1'b0, r_root} + 9'd2;
    assign w_c1   = (18'(w_r1) * 18'(w_r1)) <= 18'(w_n);
    assign w_c2   = (18'(w_r2) * 18'(w_r2)) <= 18'(w_n);

    // the root climbs by two only from the first to the second entry
    always_comb begin
        n_root = r_root;
        if (w_c1 && w_c2) begin
            n_root = w_r2[7:0];
        end else if (w_c1) begin
            n_root = w_r1[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_root <= '0;
        end else if (!w_done) begin
            r_idx  <= r_idx + 1'b1;
            r_root <= n_root;
        end
    end

    assign o_fill.we   = !w_done;
    assign o_fill.addr = r_idx[ROOT_AW-1:0];
    assign o_fill.data = n_root;
    assign o_fill.done = w_done;

endmodule

[design/text_mode_plasma_cell_generator.sv]
// An accepted cell is registered through stages 1 to 5 before o_out_valid; a low i_out_ready stalls the pipeline.
// Throughput: one cell per cycle while i_out_ready is high; the three root lookups share two
// table copies of which one reads at two addresses in a cycle.
// Reset: the colour scheme clears to 0 and the pipeline empties; the root
// tables are then refilled, one entry a cycle, through all 16384 entries, with
// o_in_ready low. Configuration writes are taken throughout.
module text_mode_plasma_cell_generator
    import ptc_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_cell_row,
    input  logic [6:0]  i_cell_col,
    input  logic [12:0] i_frame_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_cell_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    localparam logic [15:0] CX = 16'(ROWS);
    localparam logic [15:0] CY = 16'(COLS / 2);

    t_fill w_fill;
    logic  [2:0] r_color_scheme;

    // pipeline valids and stage enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;
    logic w_accept;

    assign w_en5 = !r_v5 || i_out_ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_in_ready  = w_fill.done && w_en1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    ptc_root_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_fill  (w_fill)
    );

    // stage 1: differences to the three centres
    logic [15:0] r_dx [3];
    logic [15:0] r_dy [3];
    logic [6:0]  r_t1;
    logic [15:0] n_dx [3];
    logic [15:0] n_dy [3];
    logic [15:0] w_rc;
    logic [15:0] w_cc;
    logic [7:0]  w_a2;
    logic [7:0]  w_a3;

    assign w_rc = {10'b0, i_cell_row, 1'b0};
    assign w_cc = {9'b0, i_cell_col};
    assign w_a2 = i_frame_time[12:5];
    assign w_a3 = 8'(8'd0 - 8'(i_frame_time[7:0] * 8'd3));

    always_comb begin
        n_dx[0] = w_rc - CX;
        n_dy[0] = w_cc - CY;
        n_dx[1] = w_rc - move_coord(w_a2, MOVE_OFF_A);
        n_dy[1] = w_cc - move_coord(8'(QUARTER_TURN - w_a2), MOVE_OFF_A);
        n_dx[2] = w_rc - move_coord(w_a3, MOVE_OFF_B);
        n_dy[2] = w_cc - move_coord(8'(QUARTER_TURN - w_a3), MOVE_OFF_B);
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_t1 <= i_frame_time[6:0];
        end
    end

    // stage 2: squares, low 16 bits only
    logic [15:0] r_sqx [3];
    logic [15:0] r_sqy [3];
    logic [6:0]  r_t2;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            for (int k = 0; k < 3; k++) begin
                r_sqx[k] <= 16'(r_dx[k] * r_dx[k]);
                r_sqy[k] <= 16'(r_dy[k] * r_dy[k]);
            end
            r_t2 <= r_t1;
        end
    end

    // stage 3: root lookups
    logic [15:0]        w_sum [3];
    logic [ROOT_AW-1:0] w_raddr_a [2];
    logic [ROOT_AW-1:0] w_raddr_b [1];
    logic [7:0]         w_root_a [2];
    logic [7:0]         w_root_b [1];
    logic [6:0]         r_t3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = r_sqx[k] + r_sqy[k];
        end
    end

    assign w_raddr_a[0] = w_sum[0][15:2];
    assign w_raddr_a[1] = w_sum[1][15:2];
    assign w_raddr_b[0] = w_sum[2][15:2];

    ptc_ram #(.WIDTH(8), .DEPTH(ROOT_DEPTH), .NRD(2)) u_root_a (
        .i_clk   (i_clk),
        .i_we    (w_fill.we),
        .i_waddr (w_fill.addr),
        .i_wdata (w_fill.data),
        .i_re    (w_en3),
        .i_raddr (w_raddr_a),
        .o_rdata (w_root_a)
    );

    ptc_ram #(.WIDTH(8), .DEPTH(ROOT_DEPTH), .NRD(1)) u_root_b (
        .i_clk   (i_clk),
        .i_we    (w_fill.we),
        .i_waddr (w_fill.addr),
        .i_wdata (w_fill.data),
        .i_re    (w_en3),
        .i_raddr (w_raddr_b),
        .o_rdata (w_root_b)
    );

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_t3 <= r_t2;
        end
    end

    // stage 4: sine of each distance (the first shifted by time and doubled), summed
    logic [9:0] r_vsum;
    logic [7:0] w_s1;
    logic [7:0] w_s2;
    logic [7:0] w_s3;

    assign w_s1 = sine_at({7'(w_root_a[0][6:0] + r_t3), 1'b0});
    assign w_s2 = sine_at(w_root_a[1]);
    assign w_s3 = sine_at(w_root_b[0]);

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_vsum <= {{2{w_s1[7]}}, w_s1} + {{2{w_s2[7]}}, w_s2} + {{2{w_s3[7]}}, w_s3};
        end
    end

    // stage 5: divide by three toward zero, pick glyph and colour
    logic [8:0]  w_mag;
    logic [18:0] w_prod;
    logic [6:0]  w_q;
    logic [7:0]  w_level;
    logic [7:0]  w_biased;
    logic [3:0]  w_icol;
    logic        w_low;
    logic [3:0]  w_idx_raw;
    logic [2:0]  w_idx;
    logic [7:0]  w_attr;
    logic [15:0] n_word;
    logic [15:0] r_word;

    assign w_mag    = r_vsum[9] ? 9'(-r_vsum) : r_vsum[8:0];
    assign w_prod   = 19'(w_mag) * 19'(RECIP_THIRD);
    assign w_q      = w_prod[15:9];
    assign w_level  = r_vsum[9] ? 8'(-{1'b0, w_q}) : {1'b0, w_q};
    assign w_biased = {~w_level[7], w_level[6:0]};
    assign w_icol   = w_biased[7:4];
    assign w_low    = w_icol <= 4'd8;
    assign w_idx_raw = w_low ? 4'(4'd8 - w_icol) : 4'(w_icol - 4'd8);
    // clamp the deepest low group, index 8, which has no table entry, onto entry 7
    assign w_idx    = w_idx_raw[3] ? 3'd7 : w_idx_raw[2:0];

    always_comb begin
        w_attr = SCHEME_ATTR[r_color_scheme][LEVEL_SLOT[w_idx]];
        if (w_low) begin
            w_attr = (w_attr & LOW_ATTR_KEEP) | LOW_ATTR_SET;
        end
        n_word = {w_attr, LEVEL_GLYPH[w_idx]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_color_scheme <= '0;
        end else begin
            if (w_en1) r_v1 <= w_accept;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
            if (i_cfg_valid) begin
                r_color_scheme <= i_cfg_data;
            end
        end
    end

    assign o_out_valid = r_v5;
    assign o_cell_word = r_word;

endmodule
